// ===== rtl/core/bpc_pkg.sv =====
// Shared constants, register codes and types of the pressure compensation pipeline.
package bpc_pkg;

    // Datapath word width and the divider depth that follows from it.
    localparam int DATA_W  = 32;
    // Cycles from an accepted start to the result strobe.
    localparam int LATENCY = 2 * DATA_W + 12;

    localparam int UT_W   = 16;
    localparam int UP_W   = 19;
    localparam int OSS_W  = 2;
    localparam int ADDR_W = 5;

    // Compensation constants of the integer scheme.
    localparam logic signed [31:0] TEMP_OFFSET = 32'sd4000;
    localparam logic        [31:0] B4_BIAS     = 32'd32768;
    localparam logic        [31:0] B7_SCALE    = 32'd50000;
    localparam logic signed [31:0] P_SQ_COEF   = 32'sd3038;
    localparam logic signed [31:0] P_LIN_COEF  = -32'sd7357;
    localparam logic signed [31:0] P_OFFSET    = 32'sd3791;

    // Register word index (byte address divided by four).
    typedef enum logic [2:0] {
        REG_AC1_AC2  = 3'd0,
        REG_AC3_AC4  = 3'd1,
        REG_AC5_AC6  = 3'd2,
        REG_B1_B2    = 3'd3,
        REG_MC_MD    = 3'd4,
        REG_OSS      = 3'd5
    } t_reg_idx;

endpackage

// ===== rtl/core/bpc_div.sv =====
// Unsigned restoring divider, one quotient bit per pipeline stage, with a sideband.
module bpc_div #(
    parameter int W  = bpc_pkg::DATA_W,
    parameter int SW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [W-1:0]  i_num,
    input  logic [W-1:0]  i_den,
    input  logic [SW-1:0] i_side,
    output logic          o_valid,
    output logic [W-1:0]  o_quo,
    output logic [SW-1:0] o_side
);

    logic          r_vld  [W];
    logic [W-1:0]  r_num  [W];
    logic [W-1:0]  r_rem  [W];
    logic [W-1:0]  r_quo  [W];
    logic [W-1:0]  r_den  [W];
    logic [SW-1:0] r_side [W];

    for (genvar k = 0; k < W; k++) begin : g_stage
        logic          vin;
        logic [W-1:0]  num_in, rem_in, quo_in, den_in;
        logic [SW-1:0] side_in;
        logic [W:0]    trial, diff;
        logic          ge;
        logic [W-1:0]  n_rem, n_quo, n_num;

        // Stage inputs come from the ports for the first stage, else from the prior stage.
        if (k == 0) begin : g_first
            assign vin     = i_valid;
            assign num_in  = i_num;
            assign rem_in  = '0;
            assign quo_in  = '0;
            assign den_in  = i_den;
            assign side_in = i_side;
        end else begin : g_next
            assign vin     = r_vld[k-1];
            assign num_in  = r_num[k-1];
            assign rem_in  = r_rem[k-1];
            assign quo_in  = r_quo[k-1];
            assign den_in  = r_den[k-1];
            assign side_in = r_side[k-1];
        end

        // One compare and subtract brings in the next numerator bit.
        always_comb begin
            trial = {rem_in, num_in[W-1]};
            diff  = trial - {1'b0, den_in};
            ge    = (trial >= {1'b0, den_in});
            n_rem = ge ? diff[W-1:0] : trial[W-1:0];
            n_quo = {quo_in[W-2:0], ge};
            n_num = {num_in[W-2:0], 1'b0};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else begin
                r_vld[k] <= vin;
            end
        end

        always_ff @(posedge i_clk) begin
            r_num[k]  <= n_num;
            r_rem[k]  <= n_rem;
            r_quo[k]  <= n_quo;
            r_den[k]  <= den_in;
            r_side[k] <= side_in;
        end
    end

    assign o_valid = r_vld[W-1];
    assign o_quo   = r_quo[W-1];
    assign o_side  = r_side[W-1];

endmodule

// ===== rtl/core/barometric_pressure_compensation.sv =====
// Top level of the barometric pressure compensation pipeline with its register port.
//
// A word (raw temperature and raw pressure) is taken at every clock edge at which start is
// high; busy never rises, so one word per cycle is sustained. Each word yields exactly one
// result on o_pressure_pa and o_divide_fault, shown for one cycle with o_valid. The path
// runs through the two 32-stage divider pipelines (temperature quotient and pressure
// quotient, one bit per stage) plus twelve stages of multiply and add work. The user must
// write the calibration registers through the APB port only while no word is in flight;
// the block itself does not enforce this. pready is always high.
module barometric_pressure_compensation (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [bpc_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    input  logic                       start,
    output logic                       busy,
    input  logic [bpc_pkg::UT_W-1:0]   i_raw_temperature,
    input  logic [bpc_pkg::UP_W-1:0]   i_raw_pressure,
    output logic                       o_valid,
    output logic signed [31:0]         o_pressure_pa,
    output logic                       o_divide_fault
);

    localparam int W   = bpc_pkg::DATA_W;
    localparam int UPW = bpc_pkg::UP_W;
    localparam int S1W = 2 + W + UPW;

    // Configuration registers.
    logic [31:0]               r_ac1_ac2, r_ac3_ac4, r_ac5_ac6, r_b1_b2, r_mc_md;
    logic [bpc_pkg::OSS_W-1:0] r_oss;
    bpc_pkg::t_reg_idx         reg_idx;
    logic                      cfg_wr;

    assign pready  = 1'b1;
    assign busy    = 1'b0;
    assign reg_idx = bpc_pkg::t_reg_idx'(paddr[4:2]);
    assign cfg_wr  = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ac1_ac2 <= '0;
            r_ac3_ac4 <= '0;
            r_ac5_ac6 <= '0;
            r_b1_b2   <= '0;
            r_mc_md   <= '0;
            r_oss     <= '0;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                bpc_pkg::REG_AC1_AC2: r_ac1_ac2 <= pwdata;
                bpc_pkg::REG_AC3_AC4: r_ac3_ac4 <= pwdata;
                bpc_pkg::REG_AC5_AC6: r_ac5_ac6 <= pwdata;
                bpc_pkg::REG_B1_B2:   r_b1_b2   <= pwdata;
                bpc_pkg::REG_MC_MD:   r_mc_md   <= pwdata;
                bpc_pkg::REG_OSS:     r_oss     <= pwdata[bpc_pkg::OSS_W-1:0];
                default: ;
            endcase
        end
    end

    // Register read back.
    always_comb begin
        unique case (reg_idx)
            bpc_pkg::REG_AC1_AC2: prdata = r_ac1_ac2;
            bpc_pkg::REG_AC3_AC4: prdata = r_ac3_ac4;
            bpc_pkg::REG_AC5_AC6: prdata = r_ac5_ac6;
            bpc_pkg::REG_B1_B2:   prdata = r_b1_b2;
            bpc_pkg::REG_MC_MD:   prdata = r_mc_md;
            bpc_pkg::REG_OSS:     prdata = {{(32 - bpc_pkg::OSS_W){1'b0}}, r_oss};
            default:              prdata = '0;
        endcase
    end

    // Calibration coefficients, extended to the datapath width.
    logic signed [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
    assign ac1 = 32'(signed'(r_ac1_ac2[31:16]));
    assign ac2 = 32'(signed'(r_ac1_ac2[15:0]));
    assign ac3 = 32'(signed'(r_ac3_ac4[31:16]));
    assign ac4 = {16'b0, r_ac3_ac4[15:0]};
    assign ac5 = {16'b0, r_ac5_ac6[31:16]};
    assign ac6 = {16'b0, r_ac5_ac6[15:0]};
    assign b1  = 32'(signed'(r_b1_b2[31:16]));
    assign b2  = 32'(signed'(r_b1_b2[15:0]));
    assign mc  = 32'(signed'(r_mc_md[31:16]));
    assign md  = 32'(signed'(r_mc_md[15:0]));

    // Stage A: first temperature term.
    logic               r_a_vld;
    logic signed [31:0] r_a_x1;
    logic [UPW-1:0]     r_a_up;
    logic signed [31:0] a_prod;

    always_comb begin
        a_prod = ({16'b0, i_raw_temperature} - ac6) * ac5;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_a_vld <= 1'b0;
        else          r_a_vld <= start;
    end

    always_ff @(posedge i_clk) begin
        r_a_x1 <= a_prod >>> 15;
        r_a_up <= i_raw_pressure;
    end

    // Stage B: operand magnitudes and zero check for the temperature quotient.
    logic               r_b_vld;
    logic [31:0]        r_b_num, r_b_den;
    logic [S1W-1:0]     r_b_side;
    logic signed [31:0] b_den, b_num;
    logic               b_neg, b_zero;

    always_comb begin
        b_den  = r_a_x1 + md;
        b_num  = mc <<< 11;
        b_neg  = b_den[31] ^ b_num[31];
        b_zero = (b_den == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_b_vld <= 1'b0;
        else          r_b_vld <= r_a_vld;
    end

    always_ff @(posedge i_clk) begin
        r_b_num  <= b_num[31] ? 32'(-b_num) : b_num;
        r_b_den  <= b_den[31] ? 32'(-b_den) : b_den;
        r_b_side <= {b_zero, b_neg, r_a_x1, r_a_up};
    end

    // Temperature quotient.
    logic           d1_vld;
    logic [31:0]    d1_quo;
    logic [S1W-1:0] d1_side;

    bpc_div #(.W(W), .SW(S1W)) u_div_temp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_b_vld),
        .i_num   (r_b_num),
        .i_den   (r_b_den),
        .i_side  (r_b_side),
        .o_valid (d1_vld),
        .o_quo   (d1_quo),
        .o_side  (d1_side)
    );

    // Stage C: B6 from the signed quotient.
    logic               r_c_vld, r_c_flt;
    logic signed [31:0] r_c_b6;
    logic [UPW-1:0]     r_c_up;
    logic signed [31:0] c_x2, c_x1;

    always_comb begin
        c_x2 = d1_side[S1W-2] ? 32'(-d1_quo) : d1_quo;
        c_x1 = d1_side[UPW +: W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_c_vld <= 1'b0;
        else          r_c_vld <= d1_vld;
    end

    always_ff @(posedge i_clk) begin
        r_c_flt <= d1_side[S1W-1];
        r_c_b6  <= c_x1 + c_x2 - bpc_pkg::TEMP_OFFSET;
        r_c_up  <= d1_side[UPW-1:0];
    end

    // Stage D: square of B6 and the two linear B6 terms.
    logic               r_d_vld, r_d_flt;
    logic signed [31:0] r_d_sq, r_d_t2, r_d_t3;
    logic [UPW-1:0]     r_d_up;
    logic signed [31:0] d_sq, d_p2, d_p3;

    always_comb begin
        d_sq = r_c_b6 * r_c_b6;
        d_p2 = ac2 * r_c_b6;
        d_p3 = ac3 * r_c_b6;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_d_vld <= 1'b0;
        else          r_d_vld <= r_c_vld;
    end

    always_ff @(posedge i_clk) begin
        r_d_flt <= r_c_flt;
        r_d_sq  <= d_sq >>> 12;
        r_d_t2  <= d_p2 >>> 11;
        r_d_t3  <= d_p3 >>> 13;
        r_d_up  <= r_c_up;
    end

    // Stage E: square terms scaled by b2 and b1.
    logic               r_e_vld, r_e_flt;
    logic signed [31:0] r_e_s2, r_e_s1, r_e_t2, r_e_t3;
    logic [UPW-1:0]     r_e_up;
    logic signed [31:0] e_p2, e_p1;

    always_comb begin
        e_p2 = b2 * r_d_sq;
        e_p1 = b1 * r_d_sq;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_e_vld <= 1'b0;
        else          r_e_vld <= r_d_vld;
    end

    always_ff @(posedge i_clk) begin
        r_e_flt <= r_d_flt;
        r_e_s2  <= e_p2 >>> 11;
        r_e_s1  <= e_p1 >>> 16;
        r_e_t2  <= r_d_t2;
        r_e_t3  <= r_d_t3;
        r_e_up  <= r_d_up;
    end

    // Stage F: B3 and the B4 correction term.
    logic               r_f_vld, r_f_flt;
    logic signed [31:0] r_f_b3, r_f_x3;
    logic [UPW-1:0]     r_f_up;
    logic signed [31:0] f_sum, f_shl, f_x3;

    always_comb begin
        f_sum = (ac1 <<< 2) + r_e_s2 + r_e_t2;
        f_shl = f_sum << r_oss;
        f_x3  = r_e_t3 + r_e_s1 + 32'sd2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_f_vld <= 1'b0;
        else          r_f_vld <= r_e_vld;
    end

    always_ff @(posedge i_clk) begin
        r_f_flt <= r_e_flt;
        r_f_b3  <= (f_shl + 32'sd2) >>> 2;
        r_f_x3  <= f_x3 >>> 2;
        r_f_up  <= r_e_up;
    end

    // Stage G: B4 and B7.
    logic        r_g_vld, r_g_flt;
    logic [31:0] r_g_b4, r_g_b7;
    logic [31:0] g_b4p, g_diff;

    always_comb begin
        g_b4p  = 32'(ac4) * (32'(r_f_x3) + bpc_pkg::B4_BIAS);
        g_diff = {{(32 - UPW){1'b0}}, r_f_up} - 32'(r_f_b3);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_g_vld <= 1'b0;
        else          r_g_vld <= r_f_vld;
    end

    always_ff @(posedge i_clk) begin
        r_g_flt <= r_f_flt;
        r_g_b4  <= g_b4p >> 15;
        r_g_b7  <= g_diff * (bpc_pkg::B7_SCALE >> r_oss);
    end

    // Stage H: pick the B7 split and check the pressure divisor.
    logic        r_h_vld;
    logic [31:0] r_h_num, r_h_den;
    logic [1:0]  r_h_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_h_vld <= 1'b0;
        else          r_h_vld <= r_g_vld;
    end

    always_ff @(posedge i_clk) begin
        r_h_num  <= r_g_b7[31] ? r_g_b7 : {r_g_b7[30:0], 1'b0};
        r_h_den  <= r_g_b4;
        r_h_side <= {r_g_flt | (r_g_b4 == '0), r_g_b7[31]};
    end

    // Pressure quotient.
    logic        d2_vld;
    logic [31:0] d2_quo;
    logic [1:0]  d2_side;

    bpc_div #(.W(W), .SW(2)) u_div_pres (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_h_vld),
        .i_num   (r_h_num),
        .i_den   (r_h_den),
        .i_side  (r_h_side),
        .o_valid (d2_vld),
        .o_quo   (d2_quo),
        .o_side  (d2_side)
    );

    // Stage I: undo the split.
    logic               r_i_vld, r_i_flt;
    logic signed [31:0] r_i_p;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_i_vld <= 1'b0;
        else          r_i_vld <= d2_vld;
    end

    always_ff @(posedge i_clk) begin
        r_i_flt <= d2_side[1];
        r_i_p   <= d2_side[0] ? {d2_quo[30:0], 1'b0} : d2_quo;
    end

    // Stage J: square of the coarse pressure and the linear correction.
    logic               r_j_vld, r_j_flt;
    logic signed [31:0] r_j_p, r_j_sq, r_j_x2;
    logic signed [31:0] j_ph, j_lin;

    always_comb begin
        j_ph  = r_i_p >>> 8;
        j_lin = bpc_pkg::P_LIN_COEF * r_i_p;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_j_vld <= 1'b0;
        else          r_j_vld <= r_i_vld;
    end

    always_ff @(posedge i_clk) begin
        r_j_flt <= r_i_flt;
        r_j_p   <= r_i_p;
        r_j_sq  <= j_ph * j_ph;
        r_j_x2  <= j_lin >>> 16;
    end

    // Stage K: scaled square term.
    logic               r_k_vld, r_k_flt;
    logic signed [31:0] r_k_p, r_k_x1, r_k_x2;
    logic signed [31:0] k_prod;

    always_comb begin
        k_prod = r_j_sq * bpc_pkg::P_SQ_COEF;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_k_vld <= 1'b0;
        else          r_k_vld <= r_j_vld;
    end

    always_ff @(posedge i_clk) begin
        r_k_flt <= r_j_flt;
        r_k_p   <= r_j_p;
        r_k_x1  <= k_prod >>> 16;
        r_k_x2  <= r_j_x2;
    end

    // Stage L: final correction into the output register.
    logic signed [31:0] l_corr;

    always_comb begin
        l_corr = (r_k_x1 + r_k_x2 + bpc_pkg::P_OFFSET) >>> 4;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) o_valid <= 1'b0;
        else          o_valid <= r_k_vld;
    end

    always_ff @(posedge i_clk) begin
        o_divide_fault <= r_k_flt;
        o_pressure_pa  <= r_k_flt ? 32'sd0 : r_k_p + l_corr;
    end

endmodule

// ===== rtl/core/bpc_chk.sv =====
// Port-level checks of the pressure compensation block, bound to its top level.
module bpc_chk (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       psel,
    input logic                       penable,
    input logic                       pwrite,
    input logic [bpc_pkg::ADDR_W-1:0] paddr,
    input logic [31:0]                pwdata,
    input logic [31:0]                prdata,
    input logic                       pready,
    input logic                       start,
    input logic                       busy,
    input logic [bpc_pkg::UT_W-1:0]   i_raw_temperature,
    input logic [bpc_pkg::UP_W-1:0]   i_raw_pressure,
    input logic                       o_valid,
    input logic signed [31:0]         o_pressure_pa,
    input logic                       o_divide_fault
);

    // The pipeline never refuses a word.
    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n) !busy)
        else $error("busy raised");

    // A faulted result carries zero pressure.
    a_fault_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_divide_fault) |-> (o_pressure_pa == 32'sd0))
        else $error("faulted result with nonzero pressure");

    // Every result strobe traces back to a start a fixed latency earlier.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, bpc_pkg::LATENCY))
        else $error("result without matching start");

endmodule

bind barometric_pressure_compensation bpc_chk u_bpc_chk (.*);

// ===== test/tb.sv =====
// Testbench for the barometric pressure compensation pipeline: directed and random words.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         psel = 1'b0;
    logic                         penable = 1'b0;
    logic                         pwrite = 1'b0;
    logic [bpc_pkg::ADDR_W-1:0]   paddr = '0;
    logic [31:0]                  pwdata = '0;
    logic [31:0]                  prdata;
    logic                         pready;
    logic                         start = 1'b0;
    logic                         busy;
    logic [bpc_pkg::UT_W-1:0]     i_raw_temperature = '0;
    logic [bpc_pkg::UP_W-1:0]     i_raw_pressure = '0;
    logic                         o_valid;
    logic signed [31:0]           o_pressure_pa;
    logic                         o_divide_fault;

    typedef struct packed {
        logic [31:0] pa;
        logic        fault;
    } t_pressure_result;

    // Local copy of the calibration registers.
    logic [31:0] cal_q [0:4];
    logic [1:0]  oss_q;

    t_pressure_result pressure_queue [$];
    int  error_count = 0;
    int  cycle_count = 0;
    bit  allow_idle = 1'b1;

    localparam int CYCLE_LIMIT = 400000;

    barometric_pressure_compensation u_top (.*);

    always #5 i_clk = ~i_clk;

    // Watchdog on the total run length.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL barometric_pressure_compensation");
            $finish;
        end
    end

    function automatic logic [31:0] asr(input logic [31:0] v, input int n);
        return $unsigned($signed(v) >>> n);
    endfunction

    function automatic logic [31:0] sdiv(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] ua, ub, q;
        ua = a[31] ? -a : a;
        ub = b[31] ? -b : b;
        q = ua / ub;
        return (a[31] != b[31]) ? -q : q;
    endfunction

    function automatic logic [31:0] sx(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    // Integer compensation of one raw reading pair.
    function automatic t_pressure_result compensate(input logic [15:0] ut,
                                                    input logic [18:0] up);
        logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
        logic [31:0] x1, x2, x3, b3, b4, b5, b6, b7, p, sq, den;
        t_pressure_result r;
        ac1 = sx(cal_q[0][31:16]); ac2 = sx(cal_q[0][15:0]);
        ac3 = sx(cal_q[1][31:16]); ac4 = {16'd0, cal_q[1][15:0]};
        ac5 = {16'd0, cal_q[2][31:16]}; ac6 = {16'd0, cal_q[2][15:0]};
        b1 = sx(cal_q[3][31:16]); b2 = sx(cal_q[3][15:0]);
        mc = sx(cal_q[4][31:16]); md = sx(cal_q[4][15:0]);
        r.pa = '0;
        r.fault = 1'b1;
        // Temperature part.
        x1 = asr(({16'd0, ut} - ac6) * ac5, 15);
        den = x1 + md;
        if (den == 0) return r;
        x2 = sdiv(mc << 11, den);
        b5 = x1 + x2;
        // Pressure part.
        b6 = b5 - 32'd4000;
        sq = asr(b6 * b6, 12);
        x1 = asr(b2 * sq, 11);
        x2 = asr(ac2 * b6, 11);
        x3 = x1 + x2;
        b3 = asr(((ac1 * 4 + x3) << oss_q) + 2, 2);
        x1 = asr(ac3 * b6, 13);
        x2 = asr(b1 * sq, 16);
        x3 = asr(x1 + x2 + 2, 2);
        b4 = (ac4 * (x3 + 32'd32768)) >> 15;
        if (b4 == 0) return r;
        b7 = ({13'd0, up} - b3) * (32'd50000 >> oss_q);
        if (b7 < 32'h8000_0000) p = (b7 << 1) / b4;
        else p = (b7 / b4) << 1;
        x1 = asr(p, 8) * asr(p, 8);
        x1 = asr(x1 * 32'd3038, 16);
        x2 = asr((32'd0 - 32'd7357) * p, 16);
        r.pa = p + asr(x1 + x2 + 32'd3791, 4);
        r.fault = 1'b0;
        return r;
    endfunction

    // Check each result word against the oldest expectation.
    always @(posedge i_clk) begin
        t_pressure_result exp_r;
        if (i_rst_n && o_valid) begin
            if (pressure_queue.size() == 0) begin
                $error("unexpected result pressure_pa=%0d", o_pressure_pa);
                error_count++;
            end else begin
                exp_r = pressure_queue.pop_front();
                if (o_pressure_pa !== exp_r.pa) begin
                    $error("pressure_pa expected %0d actual %0d",
                           $signed(exp_r.pa), o_pressure_pa);
                    error_count++;
                end
                if (o_divide_fault !== exp_r.fault) begin
                    $error("divide_fault expected %0b actual %0b",
                           exp_r.fault, o_divide_fault);
                    error_count++;
                end
            end
        end
    end

    task automatic idle_gap();
        int n;
        n = $urandom_range(1, 19);
        repeat (n) @(negedge i_clk);
    endtask

    // Send one word and record its expected result.
    task automatic send_word(input logic [15:0] ut, input logic [18:0] up);
        if (allow_idle && $urandom_range(0, 7) == 0) begin
            start <= 1'b0;
            idle_gap();
        end
        start <= 1'b1;
        i_raw_temperature <= ut;
        i_raw_pressure <= up;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        pressure_queue.push_back(compensate(ut, up));
        @(negedge i_clk);
    endtask

    // Stop sending at once and wait until every word has come out.
    task automatic drain();
        start <= 1'b0;
        @(negedge i_clk);
        while (pressure_queue.size() != 0) @(negedge i_clk);
        repeat (bpc_pkg::LATENCY + 4) @(negedge i_clk);
    endtask

    task automatic write_reg(input bpc_pkg::t_reg_idx idx, input logic [31:0] value);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= bpc_pkg::ADDR_W'(idx) << 2;
        pwdata <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (idx == bpc_pkg::REG_OSS) oss_q = value[1:0];
        else cal_q[idx] = value;
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        // An idle gap before returning keeps the next setup phase in a later time step.
        @(negedge i_clk);
    endtask

    // Typical datasheet calibration set with the given oversampling.
    task automatic load_typical(input logic [1:0] oss);
        write_reg(bpc_pkg::REG_AC1_AC2, {16'd408, -16'sd72});
        write_reg(bpc_pkg::REG_AC3_AC4, {-16'sd14383, 16'd32741});
        write_reg(bpc_pkg::REG_AC5_AC6, {16'd32757, 16'd23153});
        write_reg(bpc_pkg::REG_B1_B2, {16'd6190, 16'd4});
        write_reg(bpc_pkg::REG_MC_MD, {-16'sd8711, 16'd2868});
        write_reg(bpc_pkg::REG_OSS, {30'd0, oss});
    endtask

    task automatic test_reset_divide_fault();
        // All coefficients zero: the temperature divisor is zero.
        send_word(16'd0, 19'd0);
        send_word(16'hFFFF, 19'h7FFFF);
        drain();
    endtask

    task automatic test_directed();
        load_typical(2'd0);
        send_word(16'd27898, 19'd23843);
        send_word(16'd0, 19'd0);
        send_word(16'hFFFF, 19'h7FFFF);
        send_word(16'd23153, 19'h40000);
        drain();
        load_typical(2'd3);
        send_word(16'd27898, 19'd190744);
        send_word(16'hFFFF, 19'd0);
        send_word(16'd0, 19'h7FFFF);
        drain();
        // Temperature divisor zero: md = 0 and ut equal to ac6 gives x1 = 0.
        write_reg(bpc_pkg::REG_MC_MD, {16'd100, 16'd0});
        send_word(16'd23153, 19'd1000);
        drain();
        // Pressure divisor zero: ac4 = 0.
        load_typical(2'd1);
        write_reg(bpc_pkg::REG_AC3_AC4, {16'h8000, 16'd0});
        send_word(16'd30000, 19'd50000);
        drain();
        // Extreme coefficients.
        write_reg(bpc_pkg::REG_AC1_AC2, 32'h8000_7FFF);
        write_reg(bpc_pkg::REG_AC3_AC4, 32'h7FFF_FFFF);
        write_reg(bpc_pkg::REG_AC5_AC6, 32'hFFFF_FFFF);
        write_reg(bpc_pkg::REG_B1_B2, 32'h8000_8000);
        write_reg(bpc_pkg::REG_MC_MD, 32'h7FFF_8000);
        write_reg(bpc_pkg::REG_OSS, 32'd2);
        send_word(16'd0, 19'd0);
        send_word(16'hFFFF, 19'h7FFFF);
        send_word(16'h8000, 19'h2AAAA);
        drain();
    endtask

    task automatic test_random(input int words, input bit idle_on);
        int phase;
        allow_idle = idle_on;
        for (phase = 0; phase < 4; phase++) begin
            if ($urandom_range(0, 2) == 0) begin
                write_reg(bpc_pkg::REG_AC1_AC2, $urandom());
                write_reg(bpc_pkg::REG_AC3_AC4, $urandom());
                write_reg(bpc_pkg::REG_AC5_AC6, $urandom());
                write_reg(bpc_pkg::REG_B1_B2, $urandom());
                write_reg(bpc_pkg::REG_MC_MD, $urandom());
                write_reg(bpc_pkg::REG_OSS, $urandom());
            end else begin
                load_typical(2'($urandom_range(0, 3)));
            end
            repeat (words / 4) begin
                if ($urandom_range(0, 3) == 0)
                    send_word(16'($urandom()), 19'($urandom()));
                else
                    send_word(16'($urandom_range(20000, 40000)),
                              19'($urandom_range(10000, 40000) << oss_q));
            end
            drain();
        end
    endtask

    initial begin
        int i;
        for (i = 0; i < 5; i++) cal_q[i] = '0;
        oss_q = '0;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_reset_divide_fault();
        test_directed();
        test_random(800, 1'b1);
        test_random(160, 1'b0);
        if (error_count == 0)
            $display("PASS barometric_pressure_compensation");
        else
            $display("FAIL barometric_pressure_compensation");
        $finish;
    end
endmodule
